@@ rtl/lkvc_pkg.sv @@
package lkvc_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_LOOKUP = 2'd1,
		ST_UPDATE = 2'd2
	} state_t;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] lookup_key;
		logic signed [31:0] write_value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} cmd_t;

endpackage

@@ rtl/lkvc_ram.sv @@
module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/lkvc_ctrl.sv @@
module lkvc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output lkvc_pkg::cmd_t    cmd
);

	lkvc_pkg::state_t state_q, state_d;
	logic rsp_valid_q;
	logic can_commit;

	assign can_commit = !rsp_valid_q || !rsp_stall;
	assign rsp_valid  = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lkvc_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			lkvc_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = lkvc_pkg::ST_LOOKUP;
				end
			end
			lkvc_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = lkvc_pkg::ST_UPDATE;
			end
			lkvc_pkg::ST_UPDATE: begin
				if (can_commit) begin
					cmd.commit = 1'b1;
					req_stall  = 1'b0;
					if (req_valid) begin
						cmd.capture = 1'b1;
						state_d     = lkvc_pkg::ST_LOOKUP;
					end else begin
						state_d = lkvc_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = lkvc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/lkvc_datapath.sv @@
module lkvc_datapath #(
	parameter int ENTRIES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lkvc_pkg::cmd_t                  cmd,
	input  lkvc_pkg::req_t                  req,
	output lkvc_pkg::rsp_t                  rsp,
	input  logic                            cfg_wen,
	input  logic [lkvc_pkg::CAP_W-1:0]      cfg_wdata
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(ENTRIES + 1);

	logic [lkvc_pkg::CAP_W-1:0] cap_q;
	logic [OW-1:0]              occ_q;
	logic [ENTRIES-1:0]         valid_q;
	logic [lkvc_pkg::KEY_W-1:0] key_arr_q [ENTRIES];
	logic [IW-1:0]              rank_q [ENTRIES];

	logic                       op_q;
	logic [lkvc_pkg::KEY_W-1:0] key_q;
	logic [lkvc_pkg::VAL_W-1:0] wval_q;

	logic          hit_q;
	logic          evict_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] hit_rank_q;
	logic [IW-1:0] slot_q;

	logic [ENTRIES-1:0] match;
	logic               hit;
	logic [IW-1:0]      hit_idx;
	logic [IW-1:0]      hit_rank;
	logic [IW-1:0]      free_idx;
	logic [IW-1:0]      old_idx;
	logic [IW-1:0]      old_rank;
	logic               occ_lt_cap;
	logic               evict;

	logic                       ram_we;
	logic [IW-1:0]              ram_waddr;
	logic [lkvc_pkg::VAL_W-1:0] ram_rdata;
	lkvc_pkg::rsp_t             rsp_q;

	assign rsp      = rsp_q;
	assign old_rank = IW'(occ_q - OW'(1));

	always_comb begin
		hit_idx  = '0;
		hit_rank = '0;
		old_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_arr_q[i] == key_q);
			if (match[i]) begin
				hit_idx  = hit_idx | IW'(i);
				hit_rank = hit_rank | rank_q[i];
			end
			if (valid_q[i] && rank_q[i] == old_rank) begin
				old_idx = old_idx | IW'(i);
			end
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
			end
		end
		hit = |match;
	end

	// effective capacity is capacity clamped to 1..ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			occ_lt_cap = (occ_q == '0);
		end else begin
			occ_lt_cap = (32'(occ_q) < 32'(cap_q)) && (occ_q < OW'(ENTRIES));
		end
		evict = !occ_lt_cap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= lkvc_pkg::CAP_RESET;
			occ_q   <= '0;
			valid_q <= '0;
		end else begin
			if (cfg_wen) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.commit && op_q == lkvc_pkg::OP_PUT && !hit_q) begin
				valid_q[slot_q] <= 1'b1;
				if (!evict_q) begin
					occ_q <= occ_q + OW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= req.opcode;
			key_q  <= req.lookup_key;
			wval_q <= req.write_value;
		end
		if (cmd.lookup) begin
			hit_q      <= hit;
			evict_q    <= evict;
			hit_idx_q  <= hit_idx;
			hit_rank_q <= hit_rank;
			slot_q     <= evict ? old_idx : free_idx;
		end
		if (cmd.commit) begin
			if (hit_q) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && IW'(i) != hit_idx_q && rank_q[i] < hit_rank_q) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
				rank_q[hit_idx_q] <= '0;
			end else if (op_q == lkvc_pkg::OP_PUT) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && IW'(i) != slot_q) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
				rank_q[slot_q]    <= '0;
				key_arr_q[slot_q] <= key_q;
			end
			rsp_q.hit        <= hit_q;
			rsp_q.read_value <= (hit_q && op_q == lkvc_pkg::OP_GET) ? $signed(ram_rdata) : '0;
			rsp_q.evicted    <= (op_q == lkvc_pkg::OP_PUT) && !hit_q && evict_q;
		end
	end

	assign ram_we    = cmd.commit && op_q == lkvc_pkg::OP_PUT;
	assign ram_waddr = hit_q ? hit_idx_q : slot_q;

	lkvc_ram #(
		.WIDTH(lkvc_pkg::VAL_W),
		.DEPTH(ENTRIES)
	) u_value_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wval_q),
		.re   (cmd.lookup),
		.raddr(hit_idx),
		.rdata(ram_rdata)
	);

endmodule

@@ rtl/lru_key_value_cache_unit.sv @@
// Fully associative key/value cache with least-recently-used replacement.
// Request channel (req_valid / req_stall / req): opcode get or put, a key and
// a value. Response channel (rsp_valid / rsp_stall / rsp): one item per
// request with hit, read_value (get hit only) and evicted (put that had to
// replace the least recent entry).
// Config: cfg_wen writes cfg_wdata into the capacity register; 0 acts as 1,
// above ENTRIES acts as ENTRIES. Write it only while the block is idle.
// An accepted request passes through the lookup state (parallel key compare,
// registered value read) and then the update state (rank, key and value
// write-back), which loads the response register when the output register is free.
// A new request is taken in the same cycle the previous one commits.
// While rsp_stall holds a response, the next request completes its lookup
// and then waits; req_stall stays high until the response register frees.
// Reset clears all entry valid bits, occupancy and the response valid flag,
// and sets capacity to 16. Keys, values, ranks and response fields are not cleared.
module lru_key_value_cache_unit #(
	parameter int ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  lkvc_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output lkvc_pkg::rsp_t             rsp,
	input  logic                       cfg_wen,
	input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata
);

	lkvc_pkg::cmd_t cmd;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cmd      (cmd)
	);

	lkvc_datapath #(
		.ENTRIES(ENTRIES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.rsp      (rsp),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

endmodule

@@ rtl/lkvc_checker.sv @@
module lkvc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input lkvc_pkg::rsp_t rsp
);

	logic req_acc;

	assign req_acc = req_valid && !req_stall;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> req_stall)
		else $error("request taken during lookup");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_acc, 3))
		else $error("response without request three cycles earlier");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.hit && rsp.evicted) && (rsp.hit || rsp.read_value == '0))
		else $error("inconsistent response flags");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

@@ tb/tb_lru_key_value_cache_unit.sv @@
`timescale 1ns / 1ps

module tb_lru_key_value_cache_unit;

	localparam int SLOTS = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 4;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	lkvc_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	lkvc_pkg::rsp_t rsp;
	logic cfg_wen;
	logic [lkvc_pkg::CAP_W-1:0] cfg_wdata;

	lru_key_value_cache_unit #(.ENTRIES(SLOTS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	// cache shadow
	logic slot_used [SLOTS];
	logic [31:0] slot_key [SLOTS];
	logic [31:0] slot_data [SLOTS];
	int slot_age [SLOTS];
	int fill_count;
	logic [lkvc_pkg::CAP_W-1:0] cap_setting;

	lkvc_pkg::rsp_t rsp_expected_q [$];
	lkvc_pkg::rsp_t want;

	int errors;
	int items_sent;
	int hits_seen;
	int evicts_seen;
	int cycles;
	int stall_left;
	int hold_request;
	bit send_gaps;
	bit recv_gaps;

	always #4 clk = ~clk;

	function automatic lkvc_pkg::rsp_t cache_lookup_update(lkvc_pkg::req_t r);
		lkvc_pkg::rsp_t res;
		int i;
		int found;
		int slot;
		int oldest;
		int eff;
		res = '0;
		found = -1;
		for (i = 0; i < SLOTS; i++) begin
			if (found < 0 && slot_used[i] && slot_key[i] == r.lookup_key)
				found = i;
		end
		if (found >= 0) begin
			res.hit = 1'b1;
			if (r.opcode == lkvc_pkg::OP_GET)
				res.read_value = slot_data[found];
			else
				slot_data[found] = r.write_value;
			for (i = 0; i < SLOTS; i++) begin
				if (slot_used[i] && i != found && slot_age[i] < slot_age[found])
					slot_age[i]++;
			end
			slot_age[found] = 0;
		end else if (r.opcode == lkvc_pkg::OP_PUT) begin
			eff = (cap_setting == 0) ? 1 : (cap_setting > SLOTS) ? SLOTS : int'(cap_setting);
			slot = -1;
			if (fill_count < eff) begin
				for (i = 0; i < SLOTS; i++) begin
					if (slot < 0 && !slot_used[i])
						slot = i;
				end
			end
			if (slot < 0) begin
				oldest = -1;
				for (i = 0; i < SLOTS; i++) begin
					if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
						oldest = i;
				end
				if (oldest >= 0) begin
					slot_used[oldest] = 1'b0;
					if (fill_count > 0)
						fill_count--;
					res.evicted = 1'b1;
					slot = oldest;
				end else begin
					slot = 0;
				end
			end
			for (i = 0; i < SLOTS; i++) begin
				if (slot_used[i])
					slot_age[i]++;
			end
			slot_used[slot] = 1'b1;
			slot_key[slot] = r.lookup_key;
			slot_data[slot] = r.write_value;
			slot_age[slot] = 0;
			fill_count++;
		end
		return res;
	endfunction

	// response side: check and random stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_expected_q.size() == 0) begin
					$error("unexpected item: hit=%0b read_value=%0h evicted=%0b",
						rsp.hit, rsp.read_value, rsp.evicted);
					errors++;
				end else begin
					want = rsp_expected_q.pop_front();
					if (rsp.hit !== want.hit) begin
						$error("hit: expected %0b, got %0b", want.hit, rsp.hit);
						errors++;
					end
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected %0h, got %0h",
							want.read_value, rsp.read_value);
						errors++;
					end
					if (rsp.evicted !== want.evicted) begin
						$error("evicted: expected %0b, got %0b", want.evicted, rsp.evicted);
						errors++;
					end
					hits_seen += want.hit;
					evicts_seen += want.evicted;
				end
			end
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[lru_key_value_cache_unit] ERROR");
			$finish;
		end
	end

	// req_valid is left high after acceptance; callers that let time pass call drain
	task automatic send_item(input lkvc_pkg::op_t op, input logic [31:0] key,
		input logic [31:0] data);
		lkvc_pkg::req_t item;
		lkvc_pkg::rsp_t pred;
		int gap;
		item.opcode = op;
		item.lookup_key = key;
		item.write_value = data;
		gap = 0;
		if (send_gaps && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		pred = cache_lookup_update(item);
		rsp_expected_q = {rsp_expected_q, pred};
		items_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (rsp_expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cap_setting = cap;
		cfg_wen <= 1'b0;
	endtask

	task automatic test_empty_gets();
		send_item(lkvc_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h1234_5678);
		send_item(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h8000_0000);
	endtask

	task automatic test_hits_and_updates();
		send_item(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
		send_item(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
		send_item(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_item(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h0000_0000);
		send_item(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
		send_item(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0);
		send_item(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h5555_5555);
		send_item(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0);
		send_item(lkvc_pkg::OP_GET, 32'h1234_5678, 32'h0);
	endtask

	task automatic test_eviction_order();
		// capacity 2, then 0, below current occupancy: each new key evicts one; at 31 the put fills a free slot
		set_capacity(5'd2);
		send_item(lkvc_pkg::OP_PUT, 32'h0000_0010, 32'hAAAA_AAAA);
		send_item(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0);
		send_item(lkvc_pkg::OP_PUT, 32'h0000_0011, 32'h0000_0001);
		send_item(lkvc_pkg::OP_GET, 32'h0000_0010, 32'h0);
		set_capacity(5'd0);
		send_item(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0002);
		send_item(lkvc_pkg::OP_PUT, 32'h0000_0012, 32'h0000_0003);
		send_item(lkvc_pkg::OP_GET, 32'h0000_0011, 32'h0);
		set_capacity(5'd31);
		send_item(lkvc_pkg::OP_PUT, 32'h0000_0013, 32'h0000_0004);
		send_item(lkvc_pkg::OP_GET, 32'h0000_0012, 32'h0);
		set_capacity(5'd16);
	endtask

	task automatic run_random_phase(input logic [lkvc_pkg::CAP_W-1:0] cap, input int count);
		logic [31:0] pool [$];
		logic [31:0] key;
		logic [31:0] cand;
		int pool_len;
		int n;
		set_capacity(cap);
		pool_len = ((cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : int'(cap)) + $urandom_range(1, 6);
		for (n = 0; n < pool_len; n++) begin
			case ($urandom_range(0, 9))
				0: cand = 32'hFFFF_FFFF;
				1: cand = 32'h8000_0000;
				2: cand = 32'h7FFF_FFFF;
				3: cand = 32'h0000_0000;
				default: cand = $urandom;
			endcase
			pool = {pool, cand};
		end
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) == 0)
				key = $urandom;
			else
				key = pool[$urandom_range(0, pool_len - 1)];
			send_item($urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET, key,
				$urandom);
		end
	endtask

	task automatic test_random_capacities();
		run_random_phase(5'd16, 130);
		run_random_phase(5'd1, 130);
		run_random_phase(5'd0, 110);
		run_random_phase(5'd31, 130);
		run_random_phase(5'd4, 130);
		run_random_phase(5'($urandom_range(2, 15)), 130);
	endtask

	task automatic test_backpressure();
		int n;
		drain();
		send_gaps = 1'b0;
		hold_request = 300;
		for (n = 0; n < 24; n++)
			send_item($urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET,
				$urandom_range(0, 20), $urandom);
		drain();
		send_gaps = 1'b1;
	endtask

	task automatic test_full_rate();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		run_random_phase(5'd8, 100);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = lkvc_pkg::CAP_RESET;
		errors = 0;
		items_sent = 0;
		hits_seen = 0;
		evicts_seen = 0;
		cycles = 0;
		stall_left = 0;
		hold_request = 0;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i] = '0;
			slot_data[i] = '0;
			slot_age[i] = 0;
		end
		fill_count = 0;
		cap_setting = lkvc_pkg::CAP_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_gets();
		test_hits_and_updates();
		test_eviction_order();
		test_random_capacities();
		test_backpressure();
		test_full_rate();

		drain();
		repeat (8) @(posedge clk);
		$display("run: %0d items over capacities 0, 1, 2, 4, 8, 16, 31 and one random", items_sent);
		$display("run: %0d hits, %0d evictions, one long output hold", hits_seen, evicts_seen);
		if (errors == 0)
			$display("[lru_key_value_cache_unit] OK");
		else
			$display("[lru_key_value_cache_unit] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/lkvc_pkg.sv
rtl/lkvc_ram.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_datapath.sv
rtl/lru_key_value_cache_unit.sv
rtl/lkvc_checker.sv
tb/tb_lru_key_value_cache_unit.sv
